// File: rtl/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// File: rtl/ngga_pkg.sv
package ngga_pkg;

    localparam int ACC_W    = 30;
    localparam int FACTOR_W = 14;
    localparam int PROD_W   = ACC_W + FACTOR_W;
    localparam int POS_W    = 28;
    localparam int ALT_W    = 21;
    localparam int ALT_MAG_W = 20;
    localparam int SATS_W   = 7;

    // ASCII codes
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_PLUS   = 8'h2B;
    localparam logic [7:0] CHR_MINUS  = 8'h2D;
    localparam logic [7:0] CHR_POINT  = 8'h2E;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_ONE    = 8'h31;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_VT     = 8'h0B;
    localparam logic [7:0] CHR_FF     = 8'h0C;
    localparam logic [7:0] CHR_G      = 8'h47;
    localparam logic [7:0] CHR_P      = 8'h50;
    localparam logic [7:0] CHR_A      = 8'h41;

    // field numbers
    localparam logic [3:0] FLD_HEADER = 4'd0;
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_LAT    = 4'd2;
    localparam logic [3:0] FLD_LON    = 4'd4;
    localparam logic [3:0] FLD_FIX    = 4'd6;
    localparam logic [3:0] FLD_SATS   = 4'd7;
    localparam logic [3:0] FLD_ALT    = 4'd9;
    localparam logic [3:0] FIELD_MIN_COUNT = 4'd10;
    localparam logic [3:0] FIELD_MAX  = 4'd15;

    localparam logic [2:0] HDR_LEN = 3'd5;

    localparam logic [ACC_W-1:0]     ACC_MAX    = 30'd999999999;
    localparam logic [POS_W-1:0]     TIME_MAX   = 28'd240000000;
    localparam logic [POS_W-1:0]     LATLON_MAX = 28'd180000000;
    localparam logic [POS_W-1:0]     SAT_MAX    = 28'd99;
    localparam logic [ALT_MAG_W-1:0] ALT_MAX    = 20'd1000000;

    typedef struct packed {
        logic [POS_W-1:0]         latitude;
        logic [POS_W-1:0]         longitude;
        logic [POS_W-1:0]         utc_time;
        logic signed [ALT_W-1:0]  altitude;
        logic [SATS_W-1:0]        satellite_count;
        logic                     position_updated;
    } ngga_result_t;

    function automatic logic [2:0] scale_of(input logic [3:0] fld);
        logic [2:0] s;
        case (fld)
            FLD_TIME: s = 3'd3;
            FLD_LAT:  s = 3'd4;
            FLD_LON:  s = 3'd4;
            FLD_ALT:  s = 3'd1;
            default:  s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic is_numeric(input logic [3:0] fld);
        return (fld == FLD_TIME) || (fld == FLD_LAT) || (fld == FLD_LON) ||
               (fld == FLD_SATS) || (fld == FLD_ALT);
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CHR_G;
            3'd1:    c = CHR_P;
            3'd2:    c = CHR_G;
            3'd3:    c = CHR_G;
            3'd4:    c = CHR_A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [FACTOR_W-1:0] pow10(input logic [2:0] e);
        logic [FACTOR_W-1:0] f;
        case (e)
            3'd0:    f = 14'd1;
            3'd1:    f = 14'd10;
            3'd2:    f = 14'd100;
            3'd3:    f = 14'd1000;
            3'd4:    f = 14'd10000;
            default: f = 14'd1;
        endcase
        return f;
    endfunction

    function automatic logic [POS_W-1:0] cap_of(input logic [3:0] fld);
        logic [POS_W-1:0] c;
        case (fld)
            FLD_TIME: c = TIME_MAX;
            FLD_LAT:  c = LATLON_MAX;
            FLD_LON:  c = LATLON_MAX;
            default:  c = SAT_MAX;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/nmea_gga_sentence_parser.sv
// GGA sentence parser: takes one receiver byte per transfer on the s_ channel and, for every
// carriage return, delivers one transfer on the m_ channel with the stored time, position,
// altitude and satellite count, plus m_tuser set when that sentence was a GPGGA fix of
// quality 1 with at least ten fields and so refreshed the stored values. A byte sits in an
// input register, is parsed there against the sentence state, and a result lands in the
// output register; a new byte is accepted every cycle, and only a carriage return waits
// while the output register is still full. An accepted carriage return passes the input
// register and then the output register before it shows on m_tvalid.
`include "assert_macros.svh"

module nmea_gga_sentence_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] rx_byte
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // [27:0] latitude, [55:28] longitude, [83:56] utc_time,
                                     // [104:84] altitude, [111:105] satellite_count
    output logic          m_tuser    // [0] position_updated
);

    logic                    in_valid_reg, in_valid_next;
    logic [7:0]              in_byte_reg;
    logic                    m_valid_reg, m_valid_next;
    ngga_pkg::ngga_result_t  m_data_reg;
    logic                    out_free;
    logic                    byte_taken;
    logic                    result_valid;
    ngga_pkg::ngga_result_t  result;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || byte_taken;

    ngga_field_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_valid   (in_valid_reg),
        .byte_data    (in_byte_reg),
        .result_ready (out_free),
        .byte_taken   (byte_taken),
        .result_valid (result_valid),
        .result       (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        m_valid_next = m_valid_reg;
        if (result_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (result_valid) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg.satellite_count, m_data_reg.altitude, m_data_reg.utc_time,
                       m_data_reg.longitude, m_data_reg.latitude};
    assign m_tuser  = m_data_reg.position_updated;

    `ASSERT_IMPL(a_push_has_room, aclk, aresetn, result_valid, out_free, "result written over an unread transfer")
    `ASSERT_NEXT(a_stalled_byte_holds, aclk, aresetn, in_valid_reg && !byte_taken, in_valid_reg && $stable(in_byte_reg), "stalled input byte lost")

endmodule

// File: rtl/ngga_num_conv.sv
// Turn the digit accumulator of the closing field into a scaled, saturated value.
module ngga_num_conv (
    input  logic [3:0]                          field_num,
    input  logic [ngga_pkg::ACC_W-1:0]          acc,
    input  logic [2:0]                          frac,
    input  logic                                neg,
    output logic [ngga_pkg::POS_W-1:0]          uval,
    output logic signed [ngga_pkg::ALT_W-1:0]   aval
);

    logic [2:0]                         scale;
    logic [2:0]                         expo;
    logic [ngga_pkg::FACTOR_W-1:0]      factor;
    logic [ngga_pkg::PROD_W-1:0]        prod;
    logic [ngga_pkg::POS_W-1:0]         cap;
    logic [ngga_pkg::ALT_MAG_W-1:0]     alt_mag;

    always_comb begin
        scale  = ngga_pkg::scale_of(field_num);
        expo   = (frac < scale) ? 3'(scale - frac) : 3'd0;
        factor = ngga_pkg::pow10(expo);
        prod   = ngga_pkg::PROD_W'(acc) * ngga_pkg::PROD_W'(factor);
        cap    = ngga_pkg::cap_of(field_num);

        if (neg) begin
            uval = '0;
        end else if (prod > ngga_pkg::PROD_W'(cap)) begin
            uval = cap;
        end else begin
            uval = prod[ngga_pkg::POS_W-1:0];
        end

        if (prod > ngga_pkg::PROD_W'(ngga_pkg::ALT_MAX)) begin
            alt_mag = ngga_pkg::ALT_MAX;
        end else begin
            alt_mag = prod[ngga_pkg::ALT_MAG_W-1:0];
        end

        if (neg) begin
            aval = -$signed({1'b0, alt_mag});
        end else begin
            aval = $signed({1'b0, alt_mag});
        end
    end

endmodule

// File: rtl/ngga_field_parser.sv
`include "assert_macros.svh"

// Sentence state and per-byte field parsing; one byte is consumed per transfer.
module ngga_field_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    byte_valid,
    input  logic [7:0]              byte_data,
    input  logic                    result_ready,
    output logic                    byte_taken,
    output logic                    result_valid,
    output ngga_pkg::ngga_result_t  result
);

    logic [3:0]                         field_num_reg, field_num_next;
    logic                               hdr_match_reg, hdr_match_next;
    logic [2:0]                         hdr_pos_reg, hdr_pos_next;
    logic                               fix_ok_reg, fix_ok_next;
    logic [1:0]                         fix_len_reg, fix_len_next;
    logic [ngga_pkg::ACC_W-1:0]         acc_reg, acc_next;
    logic [2:0]                         frac_reg, frac_next;
    logic                               after_point_reg, after_point_next;
    logic                               neg_reg, neg_next;
    logic                               started_reg, started_next;
    logic                               stopped_reg, stopped_next;
    logic [ngga_pkg::POS_W-1:0]         pend_lat_reg, pend_lat_next;
    logic [ngga_pkg::POS_W-1:0]         pend_lon_reg, pend_lon_next;
    logic [ngga_pkg::POS_W-1:0]         pend_time_reg, pend_time_next;
    logic [ngga_pkg::SATS_W-1:0]        pend_sats_reg, pend_sats_next;
    logic signed [ngga_pkg::ALT_W-1:0]  pend_alt_reg, pend_alt_next;
    logic [ngga_pkg::POS_W-1:0]         stored_lat_reg, stored_lat_next;
    logic [ngga_pkg::POS_W-1:0]         stored_lon_reg, stored_lon_next;
    logic [ngga_pkg::POS_W-1:0]         stored_time_reg, stored_time_next;
    logic [ngga_pkg::SATS_W-1:0]        stored_sats_reg, stored_sats_next;
    logic signed [ngga_pkg::ALT_W-1:0]  stored_alt_reg, stored_alt_next;

    logic                               is_dollar, is_comma, is_cr;
    logic                               is_blank, is_sign, is_digit, is_point;
    logic [ngga_pkg::POS_W-1:0]         conv_uval;
    logic signed [ngga_pkg::ALT_W-1:0]  conv_aval;
    logic [ngga_pkg::ACC_W+3:0]         acc_x10;
    logic [ngga_pkg::ACC_W-1:0]         acc_digit;
    logic                               updated;

    ngga_num_conv u_conv (
        .field_num (field_num_reg),
        .acc       (acc_reg),
        .frac      (frac_reg),
        .neg       (neg_reg),
        .uval      (conv_uval),
        .aval      (conv_aval)
    );

    assign is_dollar = (byte_data == ngga_pkg::CHR_DOLLAR);
    assign is_comma  = (byte_data == ngga_pkg::CHR_COMMA);
    assign is_cr     = (byte_data == ngga_pkg::CHR_CR);
    assign is_blank  = (byte_data == ngga_pkg::CHR_SPACE) || (byte_data == ngga_pkg::CHR_TAB) ||
                       (byte_data == ngga_pkg::CHR_LF) || (byte_data == ngga_pkg::CHR_VT) ||
                       (byte_data == ngga_pkg::CHR_FF);
    assign is_sign   = (byte_data == ngga_pkg::CHR_PLUS) || (byte_data == ngga_pkg::CHR_MINUS);
    assign is_digit  = (byte_data >= ngga_pkg::CHR_ZERO) && (byte_data <= ngga_pkg::CHR_NINE);
    assign is_point  = (byte_data == ngga_pkg::CHR_POINT);

    // hold a carriage return until the output slot is free
    assign byte_taken   = byte_valid && (!is_cr || result_ready);
    assign result_valid = byte_taken && is_cr;

    // acc * 10 + digit, saturated
    assign acc_x10 = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} +
                     (ngga_pkg::ACC_W+4)'(byte_data[3:0]);
    assign acc_digit = (acc_x10 > (ngga_pkg::ACC_W+4)'(ngga_pkg::ACC_MAX)) ?
                       ngga_pkg::ACC_MAX : acc_x10[ngga_pkg::ACC_W-1:0];

    always_comb begin
        field_num_next   = field_num_reg;
        hdr_match_next   = hdr_match_reg;
        hdr_pos_next     = hdr_pos_reg;
        fix_ok_next      = fix_ok_reg;
        fix_len_next     = fix_len_reg;
        acc_next         = acc_reg;
        frac_next        = frac_reg;
        after_point_next = after_point_reg;
        neg_next         = neg_reg;
        started_next     = started_reg;
        stopped_next     = stopped_reg;
        pend_lat_next    = pend_lat_reg;
        pend_lon_next    = pend_lon_reg;
        pend_time_next   = pend_time_reg;
        pend_sats_next   = pend_sats_reg;
        pend_alt_next    = pend_alt_reg;
        stored_lat_next  = stored_lat_reg;
        stored_lon_next  = stored_lon_reg;
        stored_time_next = stored_time_reg;
        stored_sats_next = stored_sats_reg;
        stored_alt_next  = stored_alt_reg;
        updated          = 1'b0;

        if (byte_taken) begin
            if (is_dollar) begin
                field_num_next   = '0;
                hdr_match_next   = 1'b1;
                hdr_pos_next     = '0;
                fix_ok_next      = 1'b0;
                fix_len_next     = '0;
                acc_next         = '0;
                frac_next        = '0;
                after_point_next = 1'b0;
                neg_next         = 1'b0;
                started_next     = 1'b0;
                stopped_next     = 1'b0;
                pend_lat_next    = '0;
                pend_lon_next    = '0;
                pend_time_next   = '0;
                pend_sats_next   = '0;
                pend_alt_next    = '0;
            end else if (is_comma || is_cr) begin
                // close the current field
                if (field_num_reg == ngga_pkg::FLD_HEADER && hdr_pos_reg != ngga_pkg::HDR_LEN) begin
                    hdr_match_next = 1'b0;
                end
                if (field_num_reg == ngga_pkg::FLD_FIX && fix_len_reg == 2'd0) begin
                    fix_ok_next = 1'b0;
                end
                case (field_num_reg)
                    ngga_pkg::FLD_TIME: pend_time_next = conv_uval;
                    ngga_pkg::FLD_LAT:  pend_lat_next  = conv_uval;
                    ngga_pkg::FLD_LON:  pend_lon_next  = conv_uval;
                    ngga_pkg::FLD_SATS: pend_sats_next = conv_uval[ngga_pkg::SATS_W-1:0];
                    ngga_pkg::FLD_ALT:  pend_alt_next  = conv_aval;
                    default: ;
                endcase
                acc_next         = '0;
                frac_next        = '0;
                after_point_next = 1'b0;
                neg_next         = 1'b0;
                started_next     = 1'b0;
                stopped_next     = 1'b0;
                if (field_num_reg != ngga_pkg::FIELD_MAX) begin
                    field_num_next = field_num_reg + 4'd1;
                end
                if (field_num_next == ngga_pkg::FLD_FIX) begin
                    fix_ok_next  = 1'b1;
                    fix_len_next = '0;
                end

                if (is_cr) begin
                    updated = hdr_match_next && fix_ok_next &&
                              (field_num_next >= ngga_pkg::FIELD_MIN_COUNT);
                    if (updated) begin
                        stored_lat_next  = pend_lat_next;
                        stored_lon_next  = pend_lon_next;
                        stored_time_next = pend_time_next;
                        stored_sats_next = pend_sats_next;
                        stored_alt_next  = pend_alt_next;
                    end
                    field_num_next = '0;
                    hdr_match_next = 1'b0;
                    hdr_pos_next   = '0;
                    fix_ok_next    = 1'b0;
                    fix_len_next   = '0;
                    pend_lat_next  = '0;
                    pend_lon_next  = '0;
                    pend_time_next = '0;
                    pend_sats_next = '0;
                    pend_alt_next  = '0;
                end
            end else if (field_num_reg == ngga_pkg::FLD_HEADER) begin
                if (hdr_pos_reg < ngga_pkg::HDR_LEN &&
                    byte_data == ngga_pkg::hdr_char(hdr_pos_reg)) begin
                    hdr_pos_next = hdr_pos_reg + 3'd1;
                end else begin
                    hdr_match_next = 1'b0;
                end
            end else if (field_num_reg == ngga_pkg::FLD_FIX) begin
                if (byte_data != ngga_pkg::CHR_ONE || fix_len_reg != 2'd0) begin
                    fix_ok_next = 1'b0;
                end
                if (fix_len_reg < 2'd2) begin
                    fix_len_next = fix_len_reg + 2'd1;
                end
            end else if (ngga_pkg::is_numeric(field_num_reg) && !stopped_reg) begin
                if (!started_reg && is_blank) begin
                    // skip leading blanks
                end else if (!started_reg && is_sign) begin
                    started_next = 1'b1;
                    neg_next     = (byte_data == ngga_pkg::CHR_MINUS);
                end else if (is_digit) begin
                    started_next = 1'b1;
                    if (!after_point_reg || frac_reg < ngga_pkg::scale_of(field_num_reg)) begin
                        acc_next = acc_digit;
                        if (after_point_reg) begin
                            frac_next = frac_reg + 3'd1;
                        end
                    end
                end else if (is_point && !after_point_reg) begin
                    started_next     = 1'b1;
                    after_point_next = 1'b1;
                end else begin
                    stopped_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        result.latitude         = stored_lat_next;
        result.longitude        = stored_lon_next;
        result.utc_time         = stored_time_next;
        result.altitude         = stored_alt_next;
        result.satellite_count  = stored_sats_next;
        result.position_updated = updated;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_num_reg   <= '0;
            hdr_match_reg   <= 1'b0;
            hdr_pos_reg     <= '0;
            fix_ok_reg      <= 1'b0;
            fix_len_reg     <= '0;
            acc_reg         <= '0;
            frac_reg        <= '0;
            after_point_reg <= 1'b0;
            neg_reg         <= 1'b0;
            started_reg     <= 1'b0;
            stopped_reg     <= 1'b0;
            pend_lat_reg    <= '0;
            pend_lon_reg    <= '0;
            pend_time_reg   <= '0;
            pend_sats_reg   <= '0;
            pend_alt_reg    <= '0;
            stored_lat_reg  <= '0;
            stored_lon_reg  <= '0;
            stored_time_reg <= '0;
            stored_sats_reg <= '0;
            stored_alt_reg  <= '0;
        end else begin
            field_num_reg   <= field_num_next;
            hdr_match_reg   <= hdr_match_next;
            hdr_pos_reg     <= hdr_pos_next;
            fix_ok_reg      <= fix_ok_next;
            fix_len_reg     <= fix_len_next;
            acc_reg         <= acc_next;
            frac_reg        <= frac_next;
            after_point_reg <= after_point_next;
            neg_reg         <= neg_next;
            started_reg     <= started_next;
            stopped_reg     <= stopped_next;
            pend_lat_reg    <= pend_lat_next;
            pend_lon_reg    <= pend_lon_next;
            pend_time_reg   <= pend_time_next;
            pend_sats_reg   <= pend_sats_next;
            pend_alt_reg    <= pend_alt_next;
            stored_lat_reg  <= stored_lat_next;
            stored_lon_reg  <= stored_lon_next;
            stored_time_reg <= stored_time_next;
            stored_sats_reg <= stored_sats_next;
            stored_alt_reg  <= stored_alt_next;
        end
    end

    `ASSERT_ALWAYS(a_frac_needs_point, aclk, aresetn, after_point_reg || (frac_reg == 3'd0), "fraction digits counted without a decimal point")
    `ASSERT_NEXT(a_cr_closes_sentence, aclk, aresetn, byte_taken && is_cr, (field_num_reg == 4'd0) && !hdr_match_reg && !fix_ok_reg, "sentence state not cleared after carriage return")

endmodule
